>>> design/mdhn_pkg.sv
// Shared types and constants for the MIPS decode / hazard nop inserter.
// Holds opcode and funct codes, operation classes, result kinds and the result record.
// No dependencies.
`default_nettype none

package mdhn_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_WIDTH = 1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TEXT_BASE    = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CONTROL_NOPS = 1'd1;

  localparam logic [31:0] TEXT_BASE_RESET    = 32'h0040_0000;
  localparam logic [2:0]  CONTROL_NOPS_RESET = 3'd3;

  // register tag meaning "no destination"
  localparam logic [5:0] NO_REG = 6'h20;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA_NOP = 2'd0,
    KIND_CTRL_NOP = 2'd1,
    KIND_INSTR    = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

  // operation classes
  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_ADDU = 5'd1, OP_SUB = 5'd2, OP_SUBU = 5'd3,
    OP_SLT = 5'd4, OP_SLTU = 5'd5, OP_AND = 5'd6, OP_OR = 5'd7,
    OP_NOR = 5'd8, OP_XOR = 5'd9, OP_JR = 5'd10, OP_SRL = 5'd11,
    OP_SYSCALL = 5'd12, OP_MUL = 5'd13, OP_LW = 5'd14, OP_SW = 5'd15,
    OP_LB = 5'd16, OP_SB = 5'd17, OP_ADDI = 5'd18, OP_ADDIU = 5'd19,
    OP_SLTI = 5'd20, OP_SLTIU = 5'd21, OP_ANDI = 5'd22, OP_ORI = 5'd23,
    OP_XORI = 5'd24, OP_LUI = 5'd25, OP_BEQ = 5'd26, OP_BNE = 5'd27,
    OP_J = 5'd28, OP_JAL = 5'd29
  } op_t;

  // primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_MUL     = 6'h1C;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_SW      = 6'h2B;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTI    = 6'h0A;
  localparam logic [5:0] OPC_SLTIU   = 6'h0B;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_XORI    = 6'h0E;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;

  // SPECIAL funct codes
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_XOR     = 6'h28;

  // one emitted result (without the last flag)
  typedef struct packed {
    kind_t       kind;
    op_t         op;
    logic        has_label;
    logic [15:0] label_index;
    logic [4:0]  dest;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [4:0]  shamt;
    logic [15:0] imm;
    logic [29:0] tag;
  } res_t;

  // decoder output: the result plus hazard-tracking info
  typedef struct packed {
    logic       ok;
    logic       branch;
    logic [5:0] use_one;
    logic [5:0] use_two;
    logic [5:0] wr_reg;
    res_t       res;
  } dec_t;

endpackage

`default_nettype wire

>>> design/mdhn_decode.sv
// Combinational instruction decoder: operation class, register fields, immediate, target tag.
// Depends on mdhn_pkg.
`default_nettype none

module mdhn_decode import mdhn_pkg::*; (
  input  wire logic [31:0] word,
  input  wire logic [31:0] index32,
  input  wire logic [31:0] text_base,
  output dec_t             dec
);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] br_sum;
  logic [31:0] jmp_addr;

  assign opc = word[31:26];
  assign fn  = word[5:0];
  assign rs  = word[25:21];
  assign rt  = word[20:16];
  assign rd  = word[15:11];

  assign br_sum   = index32 + {{16{word[15]}}, word[15:0]} + 32'd1;
  assign jmp_addr = {4'd0, word[25:0], 2'b00} - text_base;

  always_comb begin
    dec = '0;
    dec.ok = 1'b1;
    dec.use_one = NO_REG;
    dec.use_two = NO_REG;
    dec.wr_reg = NO_REG;
    dec.res.kind = KIND_INSTR;
    dec.res.op = OP_ADD;
    dec.res.has_label = (index32 != 32'd0);
    dec.res.label_index = index32[15:0];
    case (opc)
      OPC_SPECIAL: begin
        case (fn)
          FN_SYSCALL: begin
            dec.res.op = OP_SYSCALL;
            dec.res.has_label = 1'b0;
          end
          FN_JR: begin
            dec.res.op = OP_JR;
            dec.use_one = {1'b0, rs};
            dec.res.src_a = rs;
          end
          FN_SRL: begin
            dec.res.op = OP_SRL;
            dec.use_two = {1'b0, rt};
            dec.wr_reg = {1'b0, rd};
            dec.res.dest = rd;
            dec.res.src_a = rt;
            dec.res.shamt = word[10:6];
          end
          default: begin
            case (fn)
              FN_ADD:  dec.res.op = OP_ADD;
              FN_ADDU: dec.res.op = OP_ADDU;
              FN_SUB:  dec.res.op = OP_SUB;
              FN_SUBU: dec.res.op = OP_SUBU;
              FN_SLT:  dec.res.op = OP_SLT;
              FN_SLTU: dec.res.op = OP_SLTU;
              FN_AND:  dec.res.op = OP_AND;
              FN_OR:   dec.res.op = OP_OR;
              FN_NOR:  dec.res.op = OP_NOR;
              FN_XOR:  dec.res.op = OP_XOR;
              default: dec.ok = 1'b0;
            endcase
            dec.use_one = {1'b0, rs};
            dec.use_two = {1'b0, rt};
            dec.wr_reg = {1'b0, rd};
            dec.res.dest = rd;
            dec.res.src_a = rs;
            dec.res.src_b = rt;
          end
        endcase
      end
      OPC_MUL: begin
        dec.res.op = OP_MUL;
        dec.use_one = {1'b0, rs};
        dec.use_two = {1'b0, rt};
        dec.wr_reg = {1'b0, rd};
        dec.res.dest = rd;
        dec.res.src_a = rs;
        dec.res.src_b = rt;
      end
      OPC_LW, OPC_SW, OPC_LB, OPC_SB, OPC_ADDI, OPC_ADDIU, OPC_SLTI, OPC_SLTIU, OPC_ANDI,
      OPC_ORI, OPC_XORI: begin
        if (opc == OPC_LW) begin
          dec.res.op = OP_LW;
        end else if (opc == OPC_SW) begin
          dec.res.op = OP_SW;
        end else if (opc == OPC_LB) begin
          dec.res.op = OP_LB;
        end else if (opc == OPC_SB) begin
          dec.res.op = OP_SB;
        end else begin
          dec.res.op = op_t'(5'(OP_ADDI) + {2'b00, opc[2:0]});
        end
        // stores record rt as a destination too
        dec.use_two = {1'b0, rs};
        dec.wr_reg = {1'b0, rt};
        dec.res.dest = rt;
        dec.res.src_a = rs;
        dec.res.src_b = rt;
        dec.res.imm = word[15:0];
      end
      OPC_LUI: begin
        dec.res.op = OP_LUI;
        dec.wr_reg = {1'b0, rt};
        dec.res.dest = rt;
        dec.res.imm = word[15:0];
      end
      OPC_BEQ, OPC_BNE: begin
        dec.res.op = (opc == OPC_BEQ) ? OP_BEQ : OP_BNE;
        dec.branch = 1'b1;
        dec.use_one = {1'b0, rs};
        dec.use_two = {1'b0, rt};
        dec.res.src_a = rs;
        dec.res.src_b = rt;
        dec.res.imm = word[15:0];
        dec.res.tag = br_sum[29:0];
      end
      OPC_J, OPC_JAL: begin
        dec.res.op = (opc == OPC_J) ? OP_J : OP_JAL;
        dec.res.tag = jmp_addr[31:2];
      end
      default: dec.ok = 1'b0;
    endcase
    // unsupported code: one error result, all fields clear
    if (!dec.ok) begin
      dec = '0;
      dec.use_one = NO_REG;
      dec.use_two = NO_REG;
      dec.wr_reg = NO_REG;
      dec.res.kind = KIND_ERROR;
    end
  end

endmodule

`default_nettype wire

>>> design/mips_decode_hazard_nop_inserter.sv
// MIPS decode stage with data- and control-hazard nop insertion.
// An accepted request waits in the input register until the result register is free, then is decoded into it.
// Throughput: one request per cycle while out_stall is low; each nop it emits (up to 2 data + 7 control) stalls input.
// Input register, decode/hazard check, then the result register that replays nops.
// Reset (rst_n low, synchronous): clear history to "no destination", index to 0, config to defaults.
// Depends on mdhn_pkg and mdhn_decode.
`default_nettype none

module mips_decode_hazard_nop_inserter import mdhn_pkg::*; #(
  parameter int INDEX_WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [31:0]                cfg_wr_data,
  // instruction requests
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [31:0]                in_instruction_word,
  // results
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [1:0]                      out_item_kind,
  output logic [4:0]                      out_op_class,
  output logic                            out_has_label,
  output logic [15:0]                     out_label_index,
  output logic [4:0]                      out_dest_reg,
  output logic [4:0]                      out_src_reg_a,
  output logic [4:0]                      out_src_reg_b,
  output logic [4:0]                      out_shift_amount,
  output logic signed [15:0]              out_immediate,
  output logic signed [29:0]              out_target_tag,
  output logic                            out_last
);

  // configuration registers
  logic [31:0] text_base_r;
  logic [2:0]  control_nops_r;

  // decode history
  logic [5:0]             prior_one_r;
  logic [5:0]             prior_two_r;
  logic [INDEX_WIDTH-1:0] index_r;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_word_r;

  // result register with pending nop counts
  logic       s2_valid_r, s2_valid_nxt;
  res_t       s2_res_r;
  logic [1:0] dnop_r, dnop_nxt;
  logic [2:0] cnop_r, cnop_nxt;

  dec_t        dec;
  logic [31:0] index32;
  logic [1:0]  dnop_new;
  logic        out_fire;
  logic        s2_done;
  logic        s2_free;
  logic        s1_adv;

  assign index32 = 32'(index_r);

  mdhn_decode u_decode (
    .word      (s1_word_r),
    .index32   (index32),
    .text_base (text_base_r),
    .dec       (dec)
  );

  // Read-after-write: the previous destination costs two nops, the one before costs one.
  always_comb begin
    dnop_new = 2'd0;
    if (prior_one_r != NO_REG && (dec.use_one == prior_one_r || dec.use_two == prior_one_r)) begin
      dnop_new = 2'd2;
    end else if (prior_two_r != NO_REG &&
                 (dec.use_one == prior_two_r || dec.use_two == prior_two_r)) begin
      dnop_new = 2'd1;
    end
  end

  // Handshake: the result register frees when its final result is taken.
  assign out_fire = s2_valid_r && !out_stall;
  assign s2_done  = (dnop_r == 2'd0) && (cnop_r == 3'd0);
  assign s2_free  = !s2_valid_r || (out_fire && s2_done);
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_base_r    <= TEXT_BASE_RESET;
      control_nops_r <= CONTROL_NOPS_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_TEXT_BASE) begin
        text_base_r <= cfg_wr_data;
      end else if (cfg_index == CFG_CONTROL_NOPS) begin
        control_nops_r <= cfg_wr_data[2:0];
      end
    end
  end

  // Input register: load whenever it is not held by a stall.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (!in_stall) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_word_r <= in_instruction_word;
    end
  end

  // History: advance only on a supported instruction; an error leaves it untouched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_one_r <= NO_REG;
      prior_two_r <= NO_REG;
      index_r     <= '0;
    end else if (s1_adv && dec.ok) begin
      prior_two_r <= prior_one_r;
      prior_one_r <= dec.wr_reg;
      index_r     <= index_r + INDEX_WIDTH'(1);
    end
  end

  // Result register: load a decoded request, then drain data nops, control nops, instruction.
  always_comb begin
    s2_valid_nxt = s2_valid_r;
    dnop_nxt     = dnop_r;
    cnop_nxt     = cnop_r;
    if (s1_adv) begin
      s2_valid_nxt = 1'b1;
      dnop_nxt     = dec.ok ? dnop_new : 2'd0;
      cnop_nxt     = (dec.ok && dec.branch) ? control_nops_r : 3'd0;
    end else if (out_fire) begin
      if (dnop_r != 2'd0) begin
        dnop_nxt = dnop_r - 2'd1;
      end else if (cnop_r != 3'd0) begin
        cnop_nxt = cnop_r - 3'd1;
      end else begin
        s2_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      dnop_r     <= 2'd0;
      cnop_r     <= 3'd0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
      dnop_r     <= dnop_nxt;
      cnop_r     <= cnop_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_res_r <= dec.res;
    end
  end

  // Output: nops show only their kind; the stored result goes out last.
  always_comb begin
    out_valid        = s2_valid_r;
    out_last         = s2_done;
    out_item_kind    = s2_res_r.kind;
    out_op_class     = s2_res_r.op;
    out_has_label    = s2_res_r.has_label;
    out_label_index  = s2_res_r.label_index;
    out_dest_reg     = s2_res_r.dest;
    out_src_reg_a    = s2_res_r.src_a;
    out_src_reg_b    = s2_res_r.src_b;
    out_shift_amount = s2_res_r.shamt;
    out_immediate    = $signed(s2_res_r.imm);
    out_target_tag   = $signed(s2_res_r.tag);
    if (!s2_done) begin
      out_item_kind    = (dnop_r != 2'd0) ? KIND_DATA_NOP : KIND_CTRL_NOP;
      out_op_class     = '0;
      out_has_label    = 1'b0;
      out_label_index  = '0;
      out_dest_reg     = '0;
      out_src_reg_a    = '0;
      out_src_reg_b    = '0;
      out_shift_amount = '0;
      out_immediate    = '0;
      out_target_tag   = '0;
    end
  end

endmodule

`default_nettype wire
